### rtl/core/lpfd_pkg.sv
// Shared types and constants of the length-prefixed frame deframer.
package lpfd_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned WordW    = 32;
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned HdrCntW  = $clog2(HdrBytes);
  localparam int unsigned CfgIdxW  = 8;

  localparam logic [WordW-1:0] MaxLenReset = 32'd1024;

  typedef enum logic [1:0] {
    STATUS_PAYLOAD   = 2'd0,
    STATUS_BAD_MAGIC = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_OVERFLOW  = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_MAGIC     = 8'd0,
    CFG_MAX_PAYLOAD_LEN = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] payload_byte;
    logic             frame_end;
    status_e          status;
  } result_t;

  typedef struct packed {
    logic [WordW-1:0] frame_magic;
    logic [WordW-1:0] max_payload_len;
  } cfg_t;

  typedef struct packed {
    logic in_payload;
    logic halted;
  } parse_stat_t;

endpackage

### rtl/core/length_prefix_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
// Takes one received byte per item and collects an 8-byte header (big-endian magic word, then
// big-endian payload length); the following length bytes come out one per item with the last
// one marked by tlast. A header with a wrong magic, a zero length or a length above
// max_payload_len yields one error item (tdata zero) and the block then drops every byte
// until reset. The header check and payload counter sit between the input and a single result
// register, and a byte is taken whenever that register is empty or being read, so throughput
// is one byte per clock; a byte's result shows on the output in the cycle after it is taken.
module length_prefix_frame_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream: tdata = rx_byte[7:0].
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [lpfd_pkg::ByteW-1:0]   s_axis_tdata_i,
  // Output stream: tdata = payload_byte[7:0], tlast = frame_end, tuser = status[1:0].
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  output logic [lpfd_pkg::ByteW-1:0]   m_axis_tdata_o,
  output logic                         m_axis_tlast_o,
  output logic [1:0]                   m_axis_tuser_o,
  // Configuration writes.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lpfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lpfd_pkg::WordW-1:0]   cfg_data_i
);
  import lpfd_pkg::*;

  cfg_t        cfg;
  result_t     res;
  result_t     out_res;
  parse_stat_t stat;
  logic        res_valid;
  logic        space;
  logic        in_fire;

  assign s_axis_tready_o = space;
  assign in_fire         = s_axis_tvalid_i && space;

  lpfd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpfd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .rx_byte_i   (s_axis_tdata_i),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .stat_o      (stat)
  );

  lpfd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .space_o (space),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = out_res.payload_byte;
  assign m_axis_tlast_o = out_res.frame_end;
  assign m_axis_tuser_o = out_res.status;

  // Once halted, the block stays halted until reset.
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.halted |=> stat.halted)
    else $error("halted flag cleared without reset");

  // A halted block produces no further results.
  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.halted |-> !res_valid)
    else $error("result produced while halted");

  // An error result always sets the halted flag.
  a_err_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.status != STATUS_PAYLOAD) |=> stat.halted)
    else $error("error result without halting");

  // Payload passing and the halted state never coexist.
  a_state_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.in_payload && stat.halted))
    else $error("payload state while halted");

endmodule

### rtl/core/lpfd_cfg.sv
// Configuration registers of the deframer.
module lpfd_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lpfd_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [lpfd_pkg::WordW-1:0]   cfg_data_i,
  output lpfd_pkg::cfg_t               cfg_o
);
  import lpfd_pkg::*;

  logic [WordW-1:0] magic_q, magic_d;
  logic [WordW-1:0] max_len_q, max_len_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    magic_d   = magic_q;
    max_len_d = max_len_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FRAME_MAGIC:     magic_d   = cfg_data_i;
        CFG_MAX_PAYLOAD_LEN: max_len_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q   <= '0;
      max_len_q <= MaxLenReset;
    end else begin
      magic_q   <= magic_d;
      max_len_q <= max_len_d;
    end
  end

  assign cfg_o.frame_magic     = magic_q;
  assign cfg_o.max_payload_len = max_len_q;

endmodule

### rtl/core/lpfd_parse.sv
// Header collection, header check and payload counting, one byte per cycle while input bytes are taken.
module lpfd_parse (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_fire_i,
  input  logic [lpfd_pkg::ByteW-1:0] rx_byte_i,
  input  lpfd_pkg::cfg_t             cfg_i,
  output logic                       res_valid_o,
  output lpfd_pkg::result_t          res_o,
  output lpfd_pkg::parse_stat_t      stat_o
);
  import lpfd_pkg::*;

  localparam int unsigned HdrKeepW = (HdrBytes - 1) * ByteW;

  logic                in_payload_q, in_payload_d;
  logic                halted_q, halted_d;
  logic [HdrCntW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [HdrKeepW-1:0] hdr_q, hdr_d;
  logic [WordW-1:0]    remain_q, remain_d;

  logic [WordW-1:0] magic;
  logic [WordW-1:0] length;

  // The oldest stored bytes form the magic word, the rest plus this byte the length.
  assign magic  = hdr_q[HdrKeepW-1 -: WordW];
  assign length = {hdr_q[WordW-ByteW-1:0], rx_byte_i};

  always_comb begin
    in_payload_d = in_payload_q;
    halted_d     = halted_q;
    hdr_cnt_d    = hdr_cnt_q;
    hdr_d        = hdr_q;
    remain_d     = remain_q;
    res_valid_o  = 1'b0;
    res_o        = '{payload_byte: rx_byte_i, frame_end: 1'b0, status: STATUS_PAYLOAD};
    if (in_fire_i && !halted_q) begin
      if (in_payload_q) begin
        res_valid_o = 1'b1;
        remain_d    = remain_q - WordW'(1);
        if (remain_q == WordW'(1)) begin
          res_o.frame_end = 1'b1;
          in_payload_d    = 1'b0;
        end
      end else if (hdr_cnt_q == HdrCntW'(HdrBytes - 1)) begin
        hdr_cnt_d = '0;
        if (magic != cfg_i.frame_magic) begin
          res_o.status = STATUS_BAD_MAGIC;
        end else if (length == '0) begin
          res_o.status = STATUS_EMPTY;
        end else if (length > cfg_i.max_payload_len) begin
          res_o.status = STATUS_OVERFLOW;
        end
        if (res_o.status != STATUS_PAYLOAD) begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = '0;
          halted_d           = 1'b1;
        end else begin
          in_payload_d = 1'b1;
          remain_d     = length;
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q + HdrCntW'(1);
        hdr_d     = {hdr_q[HdrKeepW-ByteW-1:0], rx_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_payload_q <= 1'b0;
      halted_q     <= 1'b0;
      hdr_cnt_q    <= '0;
    end else begin
      in_payload_q <= in_payload_d;
      halted_q     <= halted_d;
      hdr_cnt_q    <= hdr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_q    <= hdr_d;
    remain_q <= remain_d;
  end

  assign stat_o.in_payload = in_payload_q;
  assign stat_o.halted     = halted_q;

endmodule

### rtl/core/lpfd_out_reg.sv
// Result register toward the output stream; frees itself whenever taken.
module lpfd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lpfd_pkg::result_t res_i,
  output logic              space_o,
  output logic              valid_o,
  input  logic              ready_i,
  output lpfd_pkg::result_t res_o
);
  import lpfd_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  // A new result may enter in the same cycle the held one leaves.
  assign space_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
